FILE: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] OP_IDLE     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_WRITE    = 3'd3;
  localparam logic [2:0] OP_READ_ACK = 3'd4;
  localparam logic [2:0] OP_READ_NAK = 3'd5;

  localparam logic [3:0]  BYTE_BITS   = 4'd8;
  localparam logic [15:0] DELAY_RESET = 16'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } out_item_t;

endpackage

FILE: hdl/i2cm_fifo.sv
// ----------------------------------------------------------------------------
// i2cm_fifo
// Small synchronous queue, power-of-two depth, head shown while not empty.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts ticks, decodes the action field and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  i2cm_pkg::in_item_t command,
  input  logic              push,
  output logic              full,
  output i2cm_pkg::cmd_t    cmd,
  output logic              cmd_valid,
  input  logic              cmd_take
);

  i2cm_pkg::cmd_t decoded;
  logic           cmd_empty;

  always_comb begin
    decoded.tx_byte = command.tx_byte;
    decoded.sda_in  = command.sda_in;
    unique case (command.action) inside
      i2cm_pkg::OP_START, i2cm_pkg::OP_STOP, i2cm_pkg::OP_WRITE,
      i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NAK: decoded.op = command.action;
      default: decoded.op = i2cm_pkg::OP_IDLE;
    endcase
  end

  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (decoded),
    .full    (full),
    .pop     (cmd_take),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

FILE: hdl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one queued tick per step, drives SCL/SDA and shifts bytes.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  i2cm_pkg::cmd_t      cmd,
  input  logic                cmd_valid,
  output logic                cmd_take,
  output i2cm_pkg::out_item_t res,
  output logic                res_push,
  input  logic                res_full
);

  logic [15:0] delay_ticks;
  logic [2:0]  current_op, current_op_next;
  logic [1:0]  phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        ack_reg, ack_reg_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        done;
  logic        step;
  logic [15:0] d;
  logic [3:0]  bit_inc;

  assign step     = cmd_valid && !res_full;
  assign cmd_take = step;
  assign res_push = step;
  assign d        = (delay_ticks == '0) ? 16'd1 : delay_ticks;
  assign bit_inc  = bit_index + 4'd1;

  always_comb begin
    current_op_next = current_op;
    phase_next      = phase;
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    shift_reg_next  = shift_reg;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_reg_next    = ack_reg;
    rx_hold_next    = rx_hold;
    done            = 1'b0;
    if (current_op == i2cm_pkg::OP_IDLE) begin
      if (cmd.op != i2cm_pkg::OP_IDLE) begin
        current_op_next = cmd.op;
        phase_next      = 2'd0;
        bit_index_next  = 4'd0;
        tick_count_next = 16'd1;
        unique case (cmd.op) inside
          i2cm_pkg::OP_START: begin
            scl_level_next = 1'b1;
            sda_level_next = 1'b1;
          end
          i2cm_pkg::OP_STOP: begin
            scl_level_next = 1'b0;
            sda_level_next = 1'b0;
          end
          i2cm_pkg::OP_WRITE: begin
            shift_reg_next = cmd.tx_byte;
            sda_level_next = cmd.tx_byte[7];
          end
          default: begin
            shift_reg_next = 8'd0;
            sda_level_next = 1'b1;
          end
        endcase
      end
    end else if (tick_count >= d) begin
      tick_count_next = 16'd1;
      unique case (current_op) inside
        i2cm_pkg::OP_START: begin
          if (phase == 2'd0) begin
            sda_level_next = 1'b0;
            phase_next     = 2'd1;
          end else begin
            scl_level_next = 1'b0;
            done           = 1'b1;
          end
        end
        i2cm_pkg::OP_STOP: begin
          if (phase == 2'd0) begin
            scl_level_next = 1'b1;
            phase_next     = 2'd1;
          end else if (phase == 2'd1) begin
            sda_level_next = 1'b1;
            phase_next     = 2'd2;
          end else begin
            done = 1'b1;
          end
        end
        i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NAK: begin
          if (phase == 2'd0) begin
            scl_level_next = 1'b1;
            if (current_op == i2cm_pkg::OP_WRITE) begin
              if (bit_index == i2cm_pkg::BYTE_BITS) begin
                ack_reg_next = cmd.sda_in;
              end
            end else if (bit_index < i2cm_pkg::BYTE_BITS) begin
              shift_reg_next = {shift_reg[6:0], cmd.sda_in};
            end
            phase_next = 2'd1;
          end else begin
            scl_level_next = 1'b0;
            if (bit_index >= i2cm_pkg::BYTE_BITS) begin
              if (current_op != i2cm_pkg::OP_WRITE) begin
                rx_hold_next = shift_reg;
              end
              done = 1'b1;
            end else begin
              bit_index_next = bit_inc;
              if (bit_inc == i2cm_pkg::BYTE_BITS) begin
                sda_level_next = (current_op != i2cm_pkg::OP_READ_ACK);
              end else if (current_op == i2cm_pkg::OP_WRITE) begin
                shift_reg_next = {shift_reg[6:0], 1'b0};
                sda_level_next = shift_reg[6];
              end
              phase_next = 2'd0;
            end
          end
        end
        default: current_op_next = i2cm_pkg::OP_IDLE;
      endcase
      if (done) begin
        current_op_next = i2cm_pkg::OP_IDLE;
        phase_next      = 2'd0;
        bit_index_next  = 4'd0;
        tick_count_next = 16'd0;
      end
    end else begin
      tick_count_next = tick_count + 16'd1;
    end
  end

  always_comb begin
    res.scl_out  = scl_level_next;
    res.sda_out  = sda_level_next;
    res.busy_res = (current_op_next != i2cm_pkg::OP_IDLE);
    res.done_res = done;
    res.rx_byte  = rx_hold_next;
    res.ack_bit  = ack_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= i2cm_pkg::DELAY_RESET;
    end else if (cfg_wr_en) begin
      delay_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_op <= i2cm_pkg::OP_IDLE;
      phase      <= '0;
      bit_index  <= '0;
      tick_count <= '0;
      shift_reg  <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_reg    <= 1'b0;
      rx_hold    <= '0;
    end else if (step) begin
      current_op <= current_op_next;
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      tick_count <= tick_count_next;
      shift_reg  <= shift_reg_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_reg    <= ack_reg_next;
      rx_hold    <= rx_hold_next;
    end
  end

endmodule

FILE: hdl/i2c_master_byte_engine.sv
// Path: an accepted tick goes through the command queue register, then the
// engine step (held while the result queue is full), then the result queue.
// Throughput: one tick per cycle; the engine steps once per cycle while the
// command queue holds a tick and the result queue has room.
// Reset: queues emptied, engine idle with SCL and SDA released, delay 4.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Tick-driven I2C master: start, stop, byte write with ACK, byte read.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  i2cm_pkg::in_item_t  command,
  input  logic                push,
  output logic                full,
  output i2cm_pkg::out_item_t result,
  output logic                empty,
  input  logic                pop
);

  i2cm_pkg::cmd_t      cmd;
  logic                cmd_valid;
  logic                cmd_take;
  i2cm_pkg::out_item_t res;
  logic                res_push;
  logic                res_full;

  i2cm_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  i2cm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take),
    .res         (res),
    .res_push    (res_push),
    .res_full    (res_full)
  );

  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
